### hw/rtl/pbsg_pkg.sv
// ============================================================================
// pbsg_pkg: shared types and constants of the block-sum grid
// Field widths, operation and status codes, register indexes and the
// command and status bundles that join the controller to the datapath.
// ============================================================================
`default_nettype none

package pbsg_pkg;

  // Default grid size.
  localparam int GRID_COLS_DEF = 16;
  localparam int GRID_ROWS_DEF = 16;

  // Field widths.
  localparam int FUNC_W  = 2;
  localparam int PIX_W   = 8;
  localparam int IDX_W   = 4;
  localparam int SUM_W   = 32;
  localparam int STAT_W  = 3;
  localparam int DIM_W   = 11;
  localparam int POS_W   = 22;
  localparam int NB_W    = 4;
  localparam int CIDX_W  = 1;

  // Packed stream widths, whole bytes.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  // Operation codes carried in the input tuser.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd3;

  // Result status codes carried in the output tuser.
  localparam logic [STAT_W-1:0] STAT_ACCUM   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_PAST    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_READ    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_WRITTEN = 3'd3;
  localparam logic [STAT_W-1:0] STAT_CLEARED = 3'd4;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT = 1'b1;

  // Configuration reset values.
  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd320;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd240;

  // Which division the shared divider runs.
  typedef enum logic [1:0] {
    DSEL_POS,
    DSEL_COL,
    DSEL_ROW
  } div_sel_t;

  // Controller to datapath.
  typedef struct packed {
    logic              sweep;
    logic              div_start;
    div_sel_t          div_sel;
    logic              cap_row;
    logic              cap_gc;
    logic              cap_gr;
    logic              pix_rd;
    logic              upd;
    logic              cell_op;
    logic              out_load;
    logic [STAT_W-1:0] kind;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_done;
    logic past_frame;
    logic sweep_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/pbsg_div.sv
// ============================================================================
// pbsg_div: restoring divider, one quotient bit per cycle
// Divides a dividend by a divisor when the quotient is known to fit in the
// requested number of bits; quotient and remainder hold after done.
// ============================================================================
`default_nettype none

module pbsg_div #(
  parameter int DW = pbsg_pkg::POS_W,
  parameter int VW = pbsg_pkg::DIM_W,
  parameter int NW = pbsg_pkg::NB_W
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  input  wire logic [NW-1:0] nbits,
  output logic               busy,
  output logic               done,
  output logic [VW-1:0]      quo,
  output logic [VW-1:0]      rem
);

  logic [DW-1:0] sh;
  logic [VW-1:0] dvs;
  logic [NW-1:0] cnt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  // The partial remainder stays below the divisor, so one more bit fits.
  assign trial = {rem, sh[DW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= nbits;
      rem  <= VW'(dividend >> nbits);
      sh   <= dividend << (DW - int'(nbits));
      quo  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= ge ? VW'(diff) : VW'(trial);
      sh   <= sh << 1;
      quo  <= {quo[VW-2:0], ge};
      cnt  <= cnt - 1'b1;
      busy <= cnt != NW'(1);
      done <= cnt == NW'(1);
    end else begin
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pbsg_dpath.sv
// ============================================================================
// pbsg_dpath: datapath of the block-sum grid
// Frame size registers, pixel position, the shared divider, the cell-sum
// memory with its clearing sweep, and the result output register.
// ============================================================================
`default_nettype none

module pbsg_dpath #(
  parameter int GRID_COLS = pbsg_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = pbsg_pkg::GRID_ROWS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic [pbsg_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [pbsg_pkg::PIX_W-1:0]   in_pixel,
  input  wire logic [pbsg_pkg::IDX_W-1:0]   in_ccol,
  input  wire logic [pbsg_pkg::IDX_W-1:0]   in_crow,
  input  wire logic [pbsg_pkg::SUM_W-1:0]   in_wsum,
  input  wire logic                         cfg_wen,
  input  wire logic [pbsg_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [pbsg_pkg::DIM_W-1:0]   cfg_data,
  input  wire pbsg_pkg::cmd_t               cmd,
  output pbsg_pkg::stat_t                   stat,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [pbsg_pkg::IDX_W-1:0]        out_col,
  output logic [pbsg_pkg::IDX_W-1:0]        out_row,
  output logic [pbsg_pkg::SUM_W-1:0]        out_sum,
  output logic [pbsg_pkg::STAT_W-1:0]       out_status
);

  localparam int CELLS = GRID_COLS * GRID_ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int GMAX  = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
  localparam int QB    = (GMAX > 1) ? $clog2(GMAX) : 1;
  localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

  // Configuration and frame position.
  logic [pbsg_pkg::DIM_W-1:0] width;
  logic [pbsg_pkg::DIM_W-1:0] height;
  logic [pbsg_pkg::POS_W-1:0] total;
  logic [pbsg_pkg::POS_W-1:0] pos;

  // Latched item.
  logic [pbsg_pkg::FUNC_W-1:0] it_func;
  logic [pbsg_pkg::PIX_W-1:0]  it_pixel;
  logic [pbsg_pkg::IDX_W-1:0]  it_ccol;
  logic [pbsg_pkg::IDX_W-1:0]  it_crow;
  logic [pbsg_pkg::SUM_W-1:0]  it_wsum;

  // Grid coordinates of the current pixel.
  logic [pbsg_pkg::DIM_W-1:0] row_reg;
  logic [CW-1:0]              gc_reg;
  logic [RW-1:0]              gr_reg;
  logic [pbsg_pkg::SUM_W-1:0] sum_reg;

  // Divider hookup.
  logic [pbsg_pkg::POS_W-1:0] div_dividend;
  logic [pbsg_pkg::DIM_W-1:0] div_divisor;
  logic [pbsg_pkg::NB_W-1:0]  div_nbits;
  logic                       div_busy;
  logic                       div_done;
  logic [pbsg_pkg::DIM_W-1:0] div_quo;
  logic [pbsg_pkg::DIM_W-1:0] div_rem;

  // Memory.
  logic [pbsg_pkg::SUM_W-1:0] mem [CELLS];
  logic [pbsg_pkg::SUM_W-1:0] rd_data;
  logic [AW-1:0]              sweep_addr;
  logic                       sweep_last;
  logic [AW-1:0]              pix_addr;
  logic [AW-1:0]              cell_addr;
  logic                       in_grid;
  logic                       is_write;
  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic [pbsg_pkg::SUM_W-1:0] mem_wd;
  logic                       mem_re;
  logic [AW-1:0]              mem_ra;
  logic                       past_frame;
  logic                       out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= pbsg_pkg::WIDTH_RST;
      height <= pbsg_pkg::HEIGHT_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        pbsg_pkg::CFG_WIDTH:  width  <= cfg_data;
        pbsg_pkg::CFG_HEIGHT: height <= cfg_data;
        default: ;
      endcase
    end
  end

  // The product of two 11-bit sizes always fits the 22-bit position.
  always_ff @(posedge clk) begin
    total <= pbsg_pkg::POS_W'(width) * pbsg_pkg::POS_W'(height);
  end

  assign past_frame = pos >= total;

  always_ff @(posedge clk) begin
    if (rst || cmd.sweep) begin
      pos <= '0;
    end else if (cmd.upd) begin
      pos <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_func  <= in_func;
      it_pixel <= in_pixel;
      it_ccol  <= in_ccol;
      it_crow  <= in_crow;
      it_wsum  <= in_wsum;
    end
  end

  // Column and row first come out of position / width; each is then scaled
  // by the grid size and divided by the frame size again.
  always_comb begin
    case (cmd.div_sel)
      pbsg_pkg::DSEL_POS: begin
        div_dividend = pos;
        div_divisor  = width;
        div_nbits    = pbsg_pkg::NB_W'(pbsg_pkg::DIM_W);
      end
      pbsg_pkg::DSEL_COL: begin
        div_dividend = pbsg_pkg::POS_W'(div_rem * GRID_COLS);
        div_divisor  = width;
        div_nbits    = pbsg_pkg::NB_W'(QB);
      end
      pbsg_pkg::DSEL_ROW: begin
        div_dividend = pbsg_pkg::POS_W'(row_reg * GRID_ROWS);
        div_divisor  = height;
        div_nbits    = pbsg_pkg::NB_W'(QB);
      end
      default: begin
        div_dividend = pos;
        div_divisor  = width;
        div_nbits    = pbsg_pkg::NB_W'(pbsg_pkg::DIM_W);
      end
    endcase
  end

  pbsg_div #(
    .DW (pbsg_pkg::POS_W),
    .VW (pbsg_pkg::DIM_W),
    .NW (pbsg_pkg::NB_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .nbits    (div_nbits),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_row) row_reg <= div_quo;
    if (cmd.cap_gc)  gc_reg  <= CW'(div_quo);
    if (cmd.cap_gr)  gr_reg  <= RW'(div_quo);
    if (cmd.upd)     sum_reg <= rd_data + pbsg_pkg::SUM_W'(it_pixel);
  end

  assign pix_addr  = AW'(gr_reg * GRID_COLS + gc_reg);
  assign cell_addr = AW'(it_crow * GRID_COLS + it_ccol);
  assign in_grid   = (it_ccol < GRID_COLS) && (it_crow < GRID_ROWS);
  assign is_write  = it_func == pbsg_pkg::FUNC_WRITE;

  assign sweep_last = sweep_addr == AW'(CELLS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cell_addr;
    mem_wd = it_wsum;
    if (cmd.sweep) begin
      mem_we = 1'b1;
      mem_wa = sweep_addr;
      mem_wd = '0;
    end else if (cmd.upd) begin
      mem_we = 1'b1;
      mem_wa = pix_addr;
      mem_wd = rd_data + pbsg_pkg::SUM_W'(it_pixel);
    end else if (cmd.cell_op && is_write && in_grid) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = cmd.pix_rd || (cmd.cell_op && !is_write && in_grid);
  assign mem_ra = cmd.pix_rd ? pix_addr : cell_addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= mem[mem_ra];
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.kind;
      case (cmd.kind)
        pbsg_pkg::STAT_ACCUM: begin
          out_col <= pbsg_pkg::IDX_W'(gc_reg);
          out_row <= pbsg_pkg::IDX_W'(gr_reg);
          out_sum <= sum_reg;
        end
        pbsg_pkg::STAT_READ: begin
          out_col <= it_ccol;
          out_row <= it_crow;
          out_sum <= in_grid ? rd_data : '0;
        end
        pbsg_pkg::STAT_WRITTEN: begin
          out_col <= it_ccol;
          out_row <= it_crow;
          out_sum <= in_grid ? it_wsum : '0;
        end
        default: begin
          out_col <= '0;
          out_row <= '0;
          out_sum <= '0;
        end
      endcase
    end
  end

  assign stat.div_done   = div_done;
  assign stat.past_frame = past_frame;
  assign stat.sweep_last = sweep_last;
  assign stat.out_free   = out_free;

`ifndef SYNTHESIS
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");
  a_upd_in_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> !past_frame)
    else $error("pixel accumulated past the end of the frame");
  a_upd_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> $past(cmd.pix_rd))
    else $error("cell update without a preceding read");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire

### hw/rtl/pbsg_ctrl.sv
// ============================================================================
// pbsg_ctrl: controller of the block-sum grid
// Sequences the clearing sweep, the three divisions and the read-modify-write
// of a pixel, the cell accesses, and the hand-off of each result.
// ============================================================================
`default_nettype none

module pbsg_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [pbsg_pkg::FUNC_W-1:0] in_func,
  input  wire pbsg_pkg::stat_t             stat,
  output logic                             ready,
  output pbsg_pkg::cmd_t                   cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SWEEP,
    S_CHECK,
    S_DPOS,
    S_DCOL,
    S_DROW,
    S_RD,
    S_RDWAIT,
    S_UPD,
    S_CELL,
    S_FINISH
  } state_t;

  state_t         state;
  state_t         state_next;
  logic           ready_next;
  pbsg_pkg::cmd_t cmd_next;

  // Commands are registered: one issued on a transition acts during the
  // first cycle of the state entered.
  always_comb begin
    state_next         = state;
    ready_next         = ready;
    cmd_next           = cmd;
    cmd_next.div_start = 1'b0;
    cmd_next.cap_row   = 1'b0;
    cmd_next.cap_gc    = 1'b0;
    cmd_next.cap_gr    = 1'b0;
    cmd_next.pix_rd    = 1'b0;
    cmd_next.upd       = 1'b0;
    cmd_next.cell_op   = 1'b0;
    cmd_next.out_load  = 1'b0;
    case (state)
      S_INIT: begin
        if (stat.sweep_last) begin
          cmd_next.sweep = 1'b0;
          ready_next     = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          ready_next = 1'b0;
          case (in_func)
            pbsg_pkg::FUNC_CLEAR: begin
              cmd_next.sweep = 1'b1;
              state_next     = S_SWEEP;
            end
            pbsg_pkg::FUNC_PIXEL: begin
              state_next = S_CHECK;
            end
            pbsg_pkg::FUNC_READ: begin
              cmd_next.cell_op = 1'b1;
              cmd_next.kind    = pbsg_pkg::STAT_READ;
              state_next       = S_CELL;
            end
            pbsg_pkg::FUNC_WRITE: begin
              cmd_next.cell_op = 1'b1;
              cmd_next.kind    = pbsg_pkg::STAT_WRITTEN;
              state_next       = S_CELL;
            end
            default: begin
              ready_next = 1'b1;
            end
          endcase
        end
      end
      S_SWEEP: begin
        if (stat.sweep_last) begin
          cmd_next.sweep = 1'b0;
          cmd_next.kind  = pbsg_pkg::STAT_CLEARED;
          state_next     = S_FINISH;
        end
      end
      S_CHECK: begin
        if (stat.past_frame) begin
          cmd_next.kind = pbsg_pkg::STAT_PAST;
          state_next    = S_FINISH;
        end else begin
          cmd_next.div_start = 1'b1;
          cmd_next.div_sel   = pbsg_pkg::DSEL_POS;
          state_next         = S_DPOS;
        end
      end
      S_DPOS: begin
        if (stat.div_done) begin
          cmd_next.cap_row   = 1'b1;
          cmd_next.div_start = 1'b1;
          cmd_next.div_sel   = pbsg_pkg::DSEL_COL;
          state_next         = S_DCOL;
        end
      end
      S_DCOL: begin
        if (stat.div_done) begin
          cmd_next.cap_gc    = 1'b1;
          cmd_next.div_start = 1'b1;
          cmd_next.div_sel   = pbsg_pkg::DSEL_ROW;
          state_next         = S_DROW;
        end
      end
      S_DROW: begin
        if (stat.div_done) begin
          cmd_next.cap_gr = 1'b1;
          state_next      = S_RD;
        end
      end
      S_RD: begin
        cmd_next.pix_rd = 1'b1;
        state_next      = S_RDWAIT;
      end
      S_RDWAIT: begin
        cmd_next.upd = 1'b1;
        state_next   = S_UPD;
      end
      S_UPD: begin
        cmd_next.kind = pbsg_pkg::STAT_ACCUM;
        state_next    = S_FINISH;
      end
      S_CELL: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd_next.out_load = 1'b1;
          ready_next        = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        ready_next = 1'b1;
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      ready <= 1'b0;
      cmd   <= '{sweep: 1'b1, div_sel: pbsg_pkg::DSEL_POS,
                 kind: pbsg_pkg::STAT_CLEARED, default: 1'b0};
    end else begin
      state <= state_next;
      ready <= ready_next;
      cmd   <= cmd_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pixel_block_sum_grid.sv
// ============================================================================
// pixel_block_sum_grid: block-sum downsampling of a grey pixel stream
// Folds raster-order pixels into a grid of 32-bit cell sums, with clear,
// cell read and cell write operations.
// ============================================================================
// The block takes one item at a time and returns exactly one result item for
// each. A pixel item adds its grey level to the grid cell that its frame
// position falls in and advances the position; a pixel beyond the end of the
// frame is dropped and answered with status 1. For a pixel, one shared
// divider produces one quotient bit per cycle and runs three divisions in
// turn (position by width, then the scaled column by width and the scaled
// row by height), followed by a read-modify-write of the cell memory. A
// clear item writes zero to every cell, one cell per cycle. After reset the
// same clearing pass runs before the first item is accepted; configuration
// writes are taken at any time. The user must write the frame size registers
// only while no item is in flight; the block itself does not enforce it. A
// change takes effect from the next pixel and leaves the position where it
// is. The next item may be accepted while a result still waits on the output.
`default_nettype none

module pixel_block_sum_grid #(
  parameter int GRID_COLS = pbsg_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = pbsg_pkg::GRID_ROWS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input item stream.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [7:0] pixel, [11:8] cell_col, [15:12] cell_row, [47:16] write_sum
  input  wire logic [pbsg_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] func
  input  wire logic [pbsg_pkg::FUNC_W-1:0]     s_tuser,
  // Result item stream.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [3:0] out_col, [7:4] out_row, [39:8] cell_sum
  output logic [pbsg_pkg::OUT_DATA_W-1:0]      m_tdata,
  // [2:0] status
  output logic [pbsg_pkg::STAT_W-1:0]          m_tuser,
  // Configuration write port: index 0 frame_width, index 1 frame_height.
  input  wire logic                            cfg_wen,
  input  wire logic [pbsg_pkg::CIDX_W-1:0]     cfg_index,
  input  wire logic [pbsg_pkg::DIM_W-1:0]      cfg_data
);

  logic                         accept;
  pbsg_pkg::cmd_t               cmd;
  pbsg_pkg::stat_t              stat;
  logic [pbsg_pkg::IDX_W-1:0]   out_col;
  logic [pbsg_pkg::IDX_W-1:0]   out_row;
  logic [pbsg_pkg::SUM_W-1:0]   out_sum;

  assign accept = s_tvalid && s_tready;

  pbsg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_func (s_tuser),
    .stat    (stat),
    .ready   (s_tready),
    .cmd     (cmd)
  );

  pbsg_dpath #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_func    (s_tuser),
    .in_pixel   (s_tdata[7:0]),
    .in_ccol    (s_tdata[11:8]),
    .in_crow    (s_tdata[15:12]),
    .in_wsum    (s_tdata[47:16]),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_col    (out_col),
    .out_row    (out_row),
    .out_sum    (out_sum),
    .out_status (m_tuser)
  );

  assign m_tdata = {out_sum, out_row, out_col};

endmodule

`default_nettype wire
